>>> design/bmhq_pkg.sv
// Shared types, constants and sequencer states for the binary min-heap queue.
// No dependencies; every other design file but bmhq_ram refers to it by scoped names.
package bmhq_pkg;

	// Heap storage geometry
	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = AW + 1;

	// Field widths
	localparam int KEY_W  = 32;
	localparam int PAY_W  = 32;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_EXTRACT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK    = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Key reported when no entry is returned
	localparam logic [KEY_W-1:0] NONE_KEY = '1;

	// Capacity register reset value and the array bound in count width
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		entry_t              ent;
		logic [STAT_W-1:0]   status;
		logic [CNT_W-1:0]    count;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_ROOT,
		S_LAST,
		S_DN_CHK,
		S_DN_L,
		S_DN_R,
		S_DN_MV,
		S_DONE
	} state_t;

endpackage

>>> design/bmhq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmhq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/bmhq_seq.sv
// Heap sequencer: sift-up and sift-down over the entry RAM with one shared comparator.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bmhq_pkg::FUNC_W-1:0]   func,
	input  logic [bmhq_pkg::KEY_W-1:0]    entry_key,
	input  logic [bmhq_pkg::PAY_W-1:0]    entry_payload,
	input  logic [bmhq_pkg::CNT_W-1:0]    capacity,
	input  logic                          out_free,
	output logic                          idle,
	output logic                          done,
	output bmhq_pkg::result_t             result
);

	bmhq_pkg::state_t state_q, state_d;

	logic [bmhq_pkg::CNT_W-1:0]  fill_q;
	logic [bmhq_pkg::AW-1:0]     pos_q;
	logic [bmhq_pkg::AW-1:0]     best_addr_q;
	logic                        best_child_q;
	logic                        is_peek_q;
	bmhq_pkg::entry_t            cur_q;
	bmhq_pkg::entry_t            best_q;
	bmhq_pkg::entry_t            res_ent_q;
	logic [bmhq_pkg::STAT_W-1:0] res_status_q;

	// RAM port signals
	logic                    ram_we;
	logic [bmhq_pkg::AW-1:0] ram_waddr;
	bmhq_pkg::entry_t        ram_wdata;
	logic [bmhq_pkg::AW-1:0] ram_raddr;
	bmhq_pkg::entry_t        rd_ent;

	// Shared comparator
	logic [bmhq_pkg::KEY_W-1:0] cmp_a;
	logic [bmhq_pkg::KEY_W-1:0] cmp_b;
	logic                       lt;

	// Address arithmetic
	logic [bmhq_pkg::AW:0]      lc;
	logic [bmhq_pkg::AW:0]      rc;
	logic [bmhq_pkg::AW-1:0]    parent;
	logic                       lc_fits;
	logic                       rc_fits;
	logic [bmhq_pkg::CNT_W-1:0] limit;
	logic                       full;
	logic [bmhq_pkg::CNT_W-1:0] last_slot;

	assign lc        = {pos_q, 1'b1};
	assign rc        = lc + (bmhq_pkg::AW + 1)'(1);
	assign parent    = (pos_q - bmhq_pkg::AW'(1)) >> 1;
	assign lc_fits   = lc < fill_q;
	assign rc_fits   = rc < fill_q;
	assign limit     = (capacity < bmhq_pkg::DEPTH_CNT) ? capacity : bmhq_pkg::DEPTH_CNT;
	assign full      = fill_q >= limit;
	assign last_slot = fill_q - bmhq_pkg::CNT_W'(1);

	bmhq_ram #(
		.WIDTH ($bits(bmhq_pkg::entry_t)),
		.DEPTH (bmhq_pkg::DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (rd_ent)
	);

	// Select comparator operands per step
	always_comb begin
		case (state_q)
			bmhq_pkg::S_UP_CMP: begin
				cmp_a = cur_q.key;
				cmp_b = rd_ent.key;
			end
			bmhq_pkg::S_DN_R: begin
				cmp_a = rd_ent.key;
				cmp_b = best_q.key;
			end
			default: begin
				cmp_a = rd_ent.key;
				cmp_b = cur_q.key;
			end
		endcase
	end

	assign lt = cmp_a < cmp_b;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (start) begin
					case (func)
						bmhq_pkg::FN_INSERT:  state_d = full ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CHK;
						bmhq_pkg::FN_EXTRACT,
						bmhq_pkg::FN_PEEK:    state_d = (fill_q == '0) ? bmhq_pkg::S_DONE
						                                              : bmhq_pkg::S_ROOT;
						default:              state_d = bmhq_pkg::S_DONE;
					endcase
				end
			end
			bmhq_pkg::S_UP_CHK: state_d = (pos_q == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CMP;
			bmhq_pkg::S_UP_CMP: state_d = lt ? bmhq_pkg::S_UP_CHK : bmhq_pkg::S_DONE;
			bmhq_pkg::S_ROOT: begin
				if (is_peek_q || fill_q == bmhq_pkg::CNT_W'(1)) begin
					state_d = bmhq_pkg::S_DONE;
				end else begin
					state_d = bmhq_pkg::S_LAST;
				end
			end
			bmhq_pkg::S_LAST:   state_d = bmhq_pkg::S_DN_CHK;
			bmhq_pkg::S_DN_CHK: state_d = lc_fits ? bmhq_pkg::S_DN_L : bmhq_pkg::S_DONE;
			bmhq_pkg::S_DN_L:   state_d = rc_fits ? bmhq_pkg::S_DN_R : bmhq_pkg::S_DN_MV;
			bmhq_pkg::S_DN_R:   state_d = bmhq_pkg::S_DN_MV;
			bmhq_pkg::S_DN_MV:  state_d = best_child_q ? bmhq_pkg::S_DN_CHK : bmhq_pkg::S_DONE;
			bmhq_pkg::S_DONE:   state_d = out_free ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DONE;
			default:            state_d = bmhq_pkg::S_IDLE;
		endcase
	end

	// RAM control per step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		ram_raddr = '0;
		case (state_q)
			bmhq_pkg::S_UP_CHK: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = parent;
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				// Pull the larger parent down into the hole, or drop the new entry here
				ram_we    = 1'b1;
				ram_wdata = lt ? rd_ent : cur_q;
			end
			bmhq_pkg::S_ROOT: begin
				ram_raddr = last_slot[bmhq_pkg::AW-1:0];
			end
			bmhq_pkg::S_DN_CHK: begin
				if (lc_fits) begin
					ram_raddr = lc[bmhq_pkg::AW-1:0];
				end else begin
					ram_we = 1'b1;
				end
			end
			bmhq_pkg::S_DN_L: begin
				ram_raddr = rc[bmhq_pkg::AW-1:0];
			end
			bmhq_pkg::S_DN_MV: begin
				// Lift the smaller child into the hole, or settle the moving entry
				ram_we    = 1'b1;
				ram_wdata = best_child_q ? best_q : cur_q;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bmhq_pkg::S_IDLE && start && func == bmhq_pkg::FN_INSERT && !full) begin
				fill_q <= fill_q + bmhq_pkg::CNT_W'(1);
			end else if (state_q == bmhq_pkg::S_ROOT && !is_peek_q) begin
				fill_q <= last_slot;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (start) begin
					cur_q.key         <= entry_key;
					cur_q.payload     <= entry_payload;
					pos_q             <= fill_q[bmhq_pkg::AW-1:0];
					is_peek_q         <= func == bmhq_pkg::FN_PEEK;
					res_ent_q.key     <= bmhq_pkg::NONE_KEY;
					res_ent_q.payload <= '0;
					case (func)
						bmhq_pkg::FN_INSERT:  res_status_q <= full ? bmhq_pkg::ST_FULL
						                                           : bmhq_pkg::ST_OK;
						bmhq_pkg::FN_EXTRACT,
						bmhq_pkg::FN_PEEK:    res_status_q <= (fill_q == '0) ? bmhq_pkg::ST_EMPTY
						                                                     : bmhq_pkg::ST_OK;
						default:              res_status_q <= bmhq_pkg::ST_OK;
					endcase
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				if (lt) begin
					pos_q <= parent;
				end
			end
			bmhq_pkg::S_ROOT: begin
				res_ent_q <= rd_ent;
			end
			bmhq_pkg::S_LAST: begin
				cur_q <= rd_ent;
				pos_q <= '0;
			end
			bmhq_pkg::S_DN_L: begin
				// Left child wins only if strictly smaller than the moving entry
				best_q       <= lt ? rd_ent : cur_q;
				best_child_q <= lt;
				best_addr_q  <= lc[bmhq_pkg::AW-1:0];
			end
			bmhq_pkg::S_DN_R: begin
				// Right child wins only if strictly smaller than the current best
				if (lt) begin
					best_q       <= rd_ent;
					best_child_q <= 1'b1;
					best_addr_q  <= rc[bmhq_pkg::AW-1:0];
				end
			end
			bmhq_pkg::S_DN_MV: begin
				if (best_child_q) begin
					pos_q <= best_addr_q;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign idle          = state_q == bmhq_pkg::S_IDLE;
	assign done          = state_q == bmhq_pkg::S_DONE;
	assign result.ent    = res_ent_q;
	assign result.status = res_status_q;
	assign result.count  = fill_q;

endmodule

>>> design/binary_min_heap_queue.sv
// Top level of the binary min-heap queue: capacity register, sequencer, result register.
// Depends on bmhq_pkg and bmhq_seq.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | func, entry_key, entry_payload
//  out     | out_valid / out_ready| out_key, out_payload, status, entry_count
//  cfg     | cfg_valid / cfg_ready| cfg_data (capacity)
//
// One request at a time: in_ready is high only while the sequencer is idle. Insert moves
// the new entry up one level per parent compare until it reaches the root or a parent
// no larger than it. Extract returns the root, moves the last entry to the root and sinks
// it one level at a time while a child is strictly smaller; peek and a one-entry extract
// read only the root; refused, empty and unused-code requests skip the heap walk.
// A finished result waits in the output register while the next request runs; a stalled
// result holds the sequencer only when a second result is ready. Reset clears the count,
// sets capacity to 64; entries need no clearing.
module binary_min_heap_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bmhq_pkg::FUNC_W-1:0]   func,
	input  logic [bmhq_pkg::KEY_W-1:0]    entry_key,
	input  logic [bmhq_pkg::PAY_W-1:0]    entry_payload,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bmhq_pkg::KEY_W-1:0]    out_key,
	output logic [bmhq_pkg::PAY_W-1:0]    out_payload,
	output logic [bmhq_pkg::STAT_W-1:0]   status,
	output logic [bmhq_pkg::CNT_W-1:0]    entry_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bmhq_pkg::CNT_W-1:0]    cfg_data
);

	logic [bmhq_pkg::CNT_W-1:0] capacity_q;
	logic                       out_valid_q;
	bmhq_pkg::result_t          out_q;
	bmhq_pkg::result_t          seq_result;
	logic                       seq_idle;
	logic                       seq_done;
	logic                       out_free;
	logic                       load;

	assign cfg_ready = 1'b1;
	assign in_ready  = seq_idle;
	assign out_free  = !out_valid_q || out_ready;
	assign load      = seq_done && out_free;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bmhq_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	bmhq_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_valid && in_ready),
		.func          (func),
		.entry_key     (entry_key),
		.entry_payload (entry_payload),
		.capacity      (capacity_q),
		.out_free      (out_free),
		.idle          (seq_idle),
		.done          (seq_done),
		.result        (seq_result)
	);

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: advance on load, hold otherwise
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= seq_result;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_key     = out_q.ent.key;
	assign out_payload = out_q.ent.payload;
	assign status      = out_q.status;
	assign entry_count = out_q.count;

endmodule

>>> design/bmhq_chk.sv
// Port-level checker for the binary min-heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue.
module bmhq_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [bmhq_pkg::FUNC_W-1:0]   func,
	input logic [bmhq_pkg::KEY_W-1:0]    entry_key,
	input logic [bmhq_pkg::PAY_W-1:0]    entry_payload,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bmhq_pkg::KEY_W-1:0]    out_key,
	input logic [bmhq_pkg::PAY_W-1:0]    out_payload,
	input logic [bmhq_pkg::STAT_W-1:0]   status,
	input logic [bmhq_pkg::CNT_W-1:0]    entry_count,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [bmhq_pkg::CNT_W-1:0]    cfg_data
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_payload)
			&& $stable(status) && $stable(entry_count))
		else $error("stalled result changed");

	// One request in flight: a taken request closes the input
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input reopened right after a request");

	// Empty result carries the empty marker and a zero count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bmhq_pkg::ST_EMPTY |->
			out_key == bmhq_pkg::NONE_KEY && out_payload == '0 && entry_count == '0)
		else $error("empty result malformed");

	// Refused insert returns no entry; a valid result's count never exceeds the array and its status is a defined code
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bmhq_pkg::ST_FULL |->
			out_key == bmhq_pkg::NONE_KEY && out_payload == '0)
		else $error("full result malformed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= bmhq_pkg::DEPTH_CNT
			&& (status == bmhq_pkg::ST_OK || status == bmhq_pkg::ST_FULL
			|| status == bmhq_pkg::ST_EMPTY))
		else $error("count or status out of range");

endmodule

bind binary_min_heap_queue bmhq_chk u_bmhq_chk (.*);
